@@ rtl/core/fsla_pkg.sv @@
`timescale 1ns / 1ps

package fsla_pkg;

  localparam int MaxRequestersDefault = 16;
  localparam int ActionW = 3;
  localparam int IdW = 4;
  localparam int StatusW = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_LOCK          = 3'd0,
    ACT_TRY_LOCK      = 3'd1,
    ACT_UNLOCK        = 3'd2,
    ACT_SHARED        = 3'd3,
    ACT_TRY_SHARED    = 3'd4,
    ACT_UNLOCK_SHARED = 3'd5
  } action_t;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_DEADLOCK = 3'd3,
    ST_NOT_HELD = 3'd4,
    ST_RELEASED = 3'd5
  } result_status_t;

  typedef enum logic [1:0] {
    MODE_UNLOCKED = 2'd0,
    MODE_EXCL     = 2'd1,
    MODE_SHARED   = 2'd2
  } lock_mode_t;

  typedef enum logic [2:0] {
    RS_IDLE        = 3'd0,
    RS_HOLD_EXCL   = 3'd1,
    RS_HOLD_SHARED = 3'd2,
    RS_WAIT_EXCL   = 3'd3,
    RS_WAIT_SHARED = 3'd4
  } req_state_t;

  // one wait queue entry: waiter id and whether it waits for shared
  typedef struct packed {
    logic           shared;
    logic [IdW-1:0] id;
  } q_entry_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic emit;
    logic wake;
  } fsla_cmd_t;

  typedef struct packed {
    logic rel_ok;
    logic grantable;
  } fsla_sts_t;

endpackage

@@ rtl/core/fsla_ctrl.sv @@
`timescale 1ns / 1ps

module fsla_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fsla_pkg::fsla_sts_t sts,
  output fsla_pkg::fsla_cmd_t cmd
);
  import fsla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PEEK,
    S_WAKE,
    S_SETTLE
  } state_t;

  state_t state;
  logic   out_free;
  logic   out_load;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  // output register takes a reply or a pending item this cycle
  assign out_load = out_free &&
                    (((state == S_EVAL) && !sts.rel_ok) || (state == S_PEEK));

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.capture = in_valid;
      S_EVAL: cmd.eval = out_free;
      S_PEEK: cmd.emit = out_free;
      S_WAKE: cmd.wake = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          if (out_free) begin
            state <= sts.rel_ok ? S_PEEK : S_IDLE;
          end
        end
        S_PEEK: begin
          if (out_free) begin
            state <= sts.grantable ? S_WAKE : S_IDLE;
          end
        end
        S_WAKE:   state <= S_SETTLE;
        S_SETTLE: state <= S_PEEK;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/fsla_datapath.sv @@
`timescale 1ns / 1ps

module fsla_datapath #(
  parameter int MAX_REQUESTERS = fsla_pkg::MaxRequestersDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fsla_pkg::fsla_cmd_t           cmd,
  output fsla_pkg::fsla_sts_t           sts,
  input  logic [fsla_pkg::ActionW-1:0]  action,
  input  logic [fsla_pkg::IdW-1:0]      requester,
  output logic                          kind,
  output logic [fsla_pkg::IdW-1:0]      target,
  output logic [fsla_pkg::StatusW-1:0]  status,
  output logic                          grant_mode,
  output logic                          last
);
  import fsla_pkg::*;

  localparam int NumIds = (MAX_REQUESTERS < (1 << IdW)) ? MAX_REQUESTERS : (1 << IdW);
  localparam int IdxW   = $clog2(NumIds);
  localparam int PtrW   = $clog2(MAX_REQUESTERS);
  localparam int CntW   = $clog2(MAX_REQUESTERS + 1);
  localparam int HoldW  = $clog2(NumIds + 1);

  // latched request
  logic [ActionW-1:0] req_action;
  logic [IdW-1:0]     req_id;

  lock_mode_t        lock_mode;
  logic [HoldW-1:0]  holder_count;
  req_state_t        rs [NumIds];

  q_entry_t          queue_mem [MAX_REQUESTERS];
  q_entry_t          head_entry;
  logic [PtrW-1:0]   queue_head;
  logic [PtrW-1:0]   queue_tail;
  logic [CntW-1:0]   queue_count;

  // result waiting for the decision on its last flag
  logic              pend_kind;
  logic [IdW-1:0]    pend_target;
  result_status_t    pend_status;
  logic              pend_mode;

  result_status_t    out_status;

  logic              id_ok;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   head_idx;
  req_state_t        cur;
  logic              is_shared;
  logic              lock_ok;
  logic              grant_now;
  logic              enqueue;
  logic              rel_ok;
  result_status_t    rep_status;
  logic [HoldW-1:0]  holder_dec;
  logic              grantable;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    next_slot = (p == PtrW'(MAX_REQUESTERS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign id_ok    = ({{(32 - IdW){1'b0}}, req_id} < MAX_REQUESTERS);
  assign idx      = id_ok ? req_id[IdxW-1:0] : '0;
  assign head_idx = head_entry.id[IdxW-1:0];
  assign cur      = rs[idx];
  assign is_shared = (req_action == ACT_SHARED) || (req_action == ACT_TRY_SHARED) ||
                     (req_action == ACT_UNLOCK_SHARED);
  assign lock_ok  = (queue_count == '0) &&
                    (is_shared ? (lock_mode != MODE_EXCL) : (lock_mode == MODE_UNLOCKED));
  assign holder_dec = holder_count - HoldW'(holder_count != '0);

  always_comb begin
    rep_status = ST_REFUSED;
    grant_now  = 1'b0;
    enqueue    = 1'b0;
    rel_ok     = 1'b0;
    unique case (req_action) inside
      ACT_LOCK, ACT_TRY_LOCK, ACT_SHARED, ACT_TRY_SHARED: begin
        if (!id_ok) begin
          rep_status = ST_REFUSED;
        end else if (cur != RS_IDLE) begin
          rep_status = ST_DEADLOCK;
        end else if (lock_ok) begin
          rep_status = ST_GRANTED;
          grant_now  = 1'b1;
        end else if (req_action == ACT_TRY_LOCK || req_action == ACT_TRY_SHARED ||
                     queue_count == CntW'(MAX_REQUESTERS)) begin
          rep_status = ST_REFUSED;
        end else begin
          rep_status = ST_QUEUED;
          enqueue    = 1'b1;
        end
      end
      ACT_UNLOCK, ACT_UNLOCK_SHARED: begin
        if (!id_ok || cur != (is_shared ? RS_HOLD_SHARED : RS_HOLD_EXCL)) begin
          rep_status = ST_NOT_HELD;
        end else begin
          rep_status = ST_RELEASED;
          rel_ok     = 1'b1;
        end
      end
      default: rep_status = ST_REFUSED;
    endcase
  end

  // head waiter may be granted under the current mode
  assign grantable = (queue_count != '0) &&
                     (head_entry.shared ? (lock_mode != MODE_EXCL)
                                        : (lock_mode == MODE_UNLOCKED));

  assign sts.rel_ok    = rel_ok;
  assign sts.grantable = grantable;

  // wait queue storage, read port follows the head
  always_ff @(posedge clk) begin
    if (cmd.eval && enqueue) begin
      queue_mem[queue_tail] <= '{shared: is_shared, id: req_id};
    end
    head_entry <= queue_mem[queue_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mode    <= MODE_UNLOCKED;
      holder_count <= '0;
      queue_head   <= '0;
      queue_tail   <= '0;
      queue_count  <= '0;
      for (int i = 0; i < NumIds; i++) rs[i] <= RS_IDLE;
    end else begin
      if (cmd.eval) begin
        if (grant_now) begin
          lock_mode    <= is_shared ? MODE_SHARED : MODE_EXCL;
          rs[idx]      <= is_shared ? RS_HOLD_SHARED : RS_HOLD_EXCL;
          holder_count <= holder_count + 1'b1;
        end
        if (enqueue) begin
          rs[idx]     <= is_shared ? RS_WAIT_SHARED : RS_WAIT_EXCL;
          queue_tail  <= next_slot(queue_tail);
          queue_count <= queue_count + 1'b1;
        end
        if (rel_ok) begin
          rs[idx]      <= RS_IDLE;
          holder_count <= holder_dec;
          if (holder_dec == '0) lock_mode <= MODE_UNLOCKED;
        end
      end
      if (cmd.wake) begin
        lock_mode     <= head_entry.shared ? MODE_SHARED : MODE_EXCL;
        rs[head_idx]  <= head_entry.shared ? RS_HOLD_SHARED : RS_HOLD_EXCL;
        holder_count  <= holder_count + 1'b1;
        queue_head    <= next_slot(queue_head);
        queue_count   <= queue_count - 1'b1;
      end
    end
  end

  // request capture, pending result and output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action <= action;
      req_id     <= requester;
    end
    if (cmd.eval) begin
      if (rel_ok) begin
        pend_kind   <= 1'b0;
        pend_target <= req_id;
        pend_status <= ST_RELEASED;
        pend_mode   <= is_shared;
      end else begin
        kind       <= 1'b0;
        target     <= req_id;
        out_status <= rep_status;
        grant_mode <= is_shared;
        last       <= 1'b1;
      end
    end
    if (cmd.emit) begin
      kind       <= pend_kind;
      target     <= pend_target;
      out_status <= pend_status;
      grant_mode <= pend_mode;
      last       <= !grantable;
    end
    if (cmd.wake) begin
      pend_kind   <= 1'b1;
      pend_target <= head_entry.id;
      pend_status <= ST_GRANTED;
      pend_mode   <= head_entry.shared;
    end
  end

  assign status = out_status;

endmodule

@@ rtl/core/fifo_fair_shared_lock_arbiter_unit.sv @@
`timescale 1ns / 1ps
// fair reader-writer lock arbiter, strict first-come order
// a request is latched on accept, evaluated once the output register is free,
//   and its reply item loaded; a successful release is held back in the pending
//   register to settle its last flag; one request at a time, the next one is taken
//   only in idle; each granted waiter adds emit, grant update and head re-read
// reset: synchronous, clears lock mode, holder count, requester states and
//   queue pointers; queue storage is not cleared

module fifo_fair_shared_lock_arbiter_unit #(
  parameter int MAX_REQUESTERS = fsla_pkg::MaxRequestersDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fsla_pkg::ActionW-1:0]  action,
  input  logic [fsla_pkg::IdW-1:0]      requester,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kind,
  output logic [fsla_pkg::IdW-1:0]      target,
  output logic [fsla_pkg::StatusW-1:0]  status,
  output logic                          grant_mode,
  output logic                          last
);
  import fsla_pkg::*;

  // command and status between sequencer and datapath
  fsla_cmd_t cmd;
  fsla_sts_t sts;

  // sequencer: accept, evaluate, then walk the wait queue after a release
  fsla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // lock state, requester table, wait queue memory and output register
  fsla_datapath #(
    .MAX_REQUESTERS (MAX_REQUESTERS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .action     (action),
    .requester  (requester),
    .kind       (kind),
    .target     (target),
    .status     (status),
    .grant_mode (grant_mode),
    .last       (last)
  );

  // one request in flight: no second item straight after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request item accepted twice in a row");

  // grants to waiters always carry the granted status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> status == ST_GRANTED)
    else $error("waiter item without granted status");

  // an exclusive grant ends the wake-up run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind && !grant_mode |-> last)
    else $error("exclusive grant not marked last");

  // waking a waiter is only done after a grantable head was seen
  assert property (@(posedge clk) disable iff (rst)
    cmd.wake |-> $past(cmd.emit) && $past(sts.grantable))
    else $error("wake without grantable head");

endmodule
